// File: design/rtk_pkg.sv
// shared types, mode codes, byte constants and lookup tables for the romaji to kana converter
`timescale 1ns / 1ps
`default_nettype none

package rtk_pkg;

  // pending consonant mode
  typedef enum logic [5:0] {
    PM_NONE, PM_K, PM_S, PM_T, PM_N, PM_H, PM_F, PM_M, PM_Y, PM_R, PM_W,
    PM_L, PM_C, PM_G, PM_Z, PM_J, PM_D, PM_B, PM_P, PM_V,
    PM_KY, PM_SY, PM_SH, PM_TY, PM_CH, PM_TS, PM_NY, PM_HY, PM_FY, PM_MY,
    PM_RY, PM_GY, PM_ZY, PM_DY, PM_DH, PM_BY, PM_PY, PM_LY, PM_LT,
    PM_HW, PM_KW, PM_NW, PM_GW
  } mode_t;

  // modes below these codes have a row in the y and w glide tables
  localparam logic [5:0] Y_ROWS = 6'd19;
  localparam logic [5:0] W_ROWS = 6'd14;

  // results of one input transaction, first byte in the low bits
  typedef struct packed {
    logic [1:0]  count;
    logic [23:0] bytes;
  } res_t;

  // half-width katakana
  localparam logic [7:0] K_A        = 8'hB1;
  localparam logic [7:0] K_I        = 8'hB2;
  localparam logic [7:0] K_U        = 8'hB3;
  localparam logic [7:0] K_KA       = 8'hB6;
  localparam logic [7:0] K_SA       = 8'hBB;
  localparam logic [7:0] K_TA       = 8'hC0;
  localparam logic [7:0] K_NA       = 8'hC5;
  localparam logic [7:0] K_HA       = 8'hCA;
  localparam logic [7:0] K_MA       = 8'hCF;
  localparam logic [7:0] K_YA       = 8'hD4;
  localparam logic [7:0] K_YU       = 8'hD5;
  localparam logic [7:0] K_YO       = 8'hD6;
  localparam logic [7:0] K_RA       = 8'hD7;
  localparam logic [7:0] K_WA       = 8'hDC;
  localparam logic [7:0] K_WO       = 8'hA6;
  localparam logic [7:0] K_NN       = 8'hDD;
  localparam logic [7:0] K_VOICED   = 8'hDE;
  localparam logic [7:0] K_SEMI     = 8'hDF;
  localparam logic [7:0] K_SMALL_A  = 8'hA7;
  localparam logic [7:0] K_SMALL_E  = 8'hAA;
  localparam logic [7:0] K_SMALL_YA = 8'hAC;
  localparam logic [7:0] K_SMALL_TU = 8'hAF;
  localparam logic [7:0] K_PERIOD   = 8'hA1;
  localparam logic [7:0] K_LBRACKET = 8'hA2;
  localparam logic [7:0] K_RBRACKET = 8'hA3;
  localparam logic [7:0] K_COMMA    = 8'hA4;
  localparam logic [7:0] K_MIDDOT   = 8'hA5;

  // ascii
  localparam logic [7:0] ASC_LC_A  = 8'h61;
  localparam logic [7:0] ASC_LC_Z  = 8'h7A;
  localparam logic [7:0] ASC_UC_A  = 8'h41;
  localparam logic [7:0] ASC_UC_Z  = 8'h5A;
  localparam logic [7:0] ASC_CASE  = 8'h20;
  localparam logic [7:0] ASC_I     = 8'h69;
  localparam logic [7:0] ASC_U     = 8'h75;
  localparam logic [7:0] ASC_E     = 8'h65;
  localparam logic [7:0] ASC_O     = 8'h6F;
  localparam logic [7:0] ASC_Y     = 8'h79;
  localparam logic [7:0] ASC_W     = 8'h77;
  localparam logic [7:0] ASC_C     = 8'h63;
  localparam logic [7:0] ASC_H     = 8'h68;
  localparam logic [7:0] ASC_T     = 8'h74;
  localparam logic [7:0] ASC_S     = 8'h73;
  localparam logic [7:0] ASC_N     = 8'h6E;
  localparam logic [7:0] ASC_DOT   = 8'h2E;
  localparam logic [7:0] ASC_LBR   = 8'h5B;
  localparam logic [7:0] ASC_RBR   = 8'h5D;
  localparam logic [7:0] ASC_COMMA = 8'h2C;
  localparam logic [7:0] ASC_SLASH = 8'h2F;
  localparam logic [7:0] ASC_APOS  = 8'h27;
  localparam logic [7:0] ASC_SPACE = 8'h20;

  // shift-jis lead byte ranges
  localparam logic [7:0] SJ_LEAD1_LO = 8'h81;
  localparam logic [7:0] SJ_LEAD1_HI = 8'h9F;
  localparam logic [7:0] SJ_LEAD2_LO = 8'hE0;
  localparam logic [7:0] SJ_LEAD2_HI = 8'hFC;

  // first kana of the row that a mode builds on
  function automatic logic [7:0] base_of_mode(logic [5:0] m);
    logic [7:0] b;
    case (m)
      PM_NONE, PM_V:                             b = K_A;
      PM_K, PM_G, PM_KY, PM_GY, PM_KW, PM_GW:    b = K_KA;
      PM_S, PM_C, PM_Z, PM_J, PM_SY, PM_SH,
      PM_ZY:                                     b = K_SA;
      PM_T, PM_D, PM_TY, PM_CH, PM_TS, PM_DY,
      PM_DH:                                     b = K_TA;
      PM_N, PM_NY, PM_NW:                        b = K_NA;
      PM_H, PM_F, PM_B, PM_P, PM_HY, PM_FY,
      PM_BY, PM_PY, PM_HW:                       b = K_HA;
      PM_M, PM_MY:                               b = K_MA;
      PM_Y:                                      b = K_YA;
      PM_R, PM_RY:                               b = K_RA;
      PM_W:                                      b = K_WA;
      PM_L:                                      b = K_SMALL_A;
      PM_LY:                                     b = K_SMALL_YA;
      PM_LT:                                     b = K_SMALL_TU;
      default:                                   b = 8'h00;
    endcase
    return b;
  endfunction

  // letter a..z: vowels give their column 0..4, consonants their mode
  function automatic logic [5:0] letter_code(logic [4:0] idx);
    logic [5:0] r;
    case (idx)
      5'd0:    r = 6'd0;
      5'd1:    r = PM_B;
      5'd2:    r = PM_C;
      5'd3:    r = PM_D;
      5'd4:    r = 6'd3;
      5'd5:    r = PM_F;
      5'd6:    r = PM_G;
      5'd7:    r = PM_H;
      5'd8:    r = 6'd1;
      5'd9:    r = PM_J;
      5'd10:   r = PM_K;
      5'd11:   r = PM_L;
      5'd12:   r = PM_M;
      5'd13:   r = PM_N;
      5'd14:   r = 6'd4;
      5'd15:   r = PM_P;
      5'd16:   r = PM_NONE;
      5'd17:   r = PM_R;
      5'd18:   r = PM_S;
      5'd19:   r = PM_T;
      5'd20:   r = 6'd2;
      5'd21:   r = PM_V;
      5'd22:   r = PM_W;
      5'd23:   r = PM_L;
      5'd24:   r = PM_Y;
      5'd25:   r = PM_Z;
      default: r = PM_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] y_glide(logic [5:0] m);
    logic [5:0] r;
    case (m)
      PM_K:       r = PM_KY;
      PM_S:       r = PM_SY;
      PM_T, PM_C: r = PM_TY;
      PM_N:       r = PM_NY;
      PM_H:       r = PM_HY;
      PM_F:       r = PM_FY;
      PM_M:       r = PM_MY;
      PM_R:       r = PM_RY;
      PM_L:       r = PM_LY;
      PM_G:       r = PM_GY;
      PM_Z, PM_J: r = PM_ZY;
      PM_D:       r = PM_DY;
      PM_B:       r = PM_BY;
      PM_P:       r = PM_PY;
      default:    r = PM_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] w_glide(logic [5:0] m);
    logic [5:0] r;
    case (m)
      PM_K:    r = PM_KW;
      PM_N:    r = PM_NW;
      PM_H:    r = PM_HW;
      PM_G:    r = PM_GW;
      default: r = PM_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] small_y(logic [5:0] v);
    logic [7:0] r;
    case (v)
      6'd0:    r = 8'hAC;
      6'd1:    r = 8'hA8;
      6'd2:    r = 8'hAD;
      6'd3:    r = 8'hAA;
      6'd4:    r = 8'hAE;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic is_voiced(logic [5:0] m);
    return (m >= PM_G && m <= PM_B) || m == PM_V ||
           (m >= PM_GY && m <= PM_BY) || m == PM_GW;
  endfunction

endpackage

`default_nettype wire

// File: design/romaji_to_kana_converter.sv
// top level of the romaji to half-width katakana converter
//
//  channel  dir  tdata               tlast        tuser
//  in_      in   [7:0] char_byte     end_of_text  -
//  out_     out  [7:0] kana_byte     last_of_run  -
//
// one input transaction per cycle while each byte yields at most one result and out_tready stays high
// a byte that yields two or three results holds off the next byte until its last result is taken
// a byte that yields nothing is consumed without touching the output side
// each byte passes the input register and then the result register before its first result is valid
// synchronous active-low reset clears the pending mode, the trail flag and both valid flags
// a stall on out_tready backs up into in_tready once the input register is full
`timescale 1ns / 1ps
`default_nettype none

module romaji_to_kana_converter
  import rtk_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] char_byte
  input  wire logic       in_tlast,   // end_of_text
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] kana_byte
  output logic            out_tlast   // last_of_run
);

  // input register
  logic       in_valid_r;
  logic [7:0] byte_r;
  logic       eot_r;

  // conversion state
  mode_t      mode_r;
  mode_t      mode_nxt;
  logic       trail_r;
  logic       trail_nxt;

  res_t       res;
  logic       buf_free;
  logic       consume;
  logic       load;

  // the registered byte moves on once the result register can take its results
  assign consume   = in_valid_r && buf_free;
  assign load      = consume && (res.count != 2'd0);
  assign in_tready = !in_valid_r || buf_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (consume) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_tdata;
      eot_r  <= in_tlast;
    end
  end

  // mode and trail flag advance once per consumed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= PM_NONE;
      trail_r <= 1'b0;
    end else if (consume) begin
      mode_r  <= mode_nxt;
      trail_r <= trail_nxt;
    end
  end

  rtk_decode u_decode (
    .char_byte_i   (byte_r),
    .end_of_text_i (eot_r),
    .mode_i        (mode_r),
    .trail_i       (trail_r),
    .res_o         (res),
    .mode_nxt_o    (mode_nxt),
    .trail_nxt_o   (trail_nxt)
  );

  rtk_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_i     (load),
    .res_i      (res),
    .free_o     (buf_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// File: design/rtk_decode.sv
// combinational conversion of one byte into up to three kana bytes and the next mode
`timescale 1ns / 1ps
`default_nettype none

module rtk_decode
  import rtk_pkg::*;
(
  input  wire logic [7:0] char_byte_i,
  input  wire logic       end_of_text_i,
  input  wire mode_t      mode_i,
  input  wire logic       trail_i,
  output res_t            res_o,
  output mode_t           mode_nxt_o,
  output logic            trail_nxt_o
);

  // place a byte at result slot n
  function automatic logic [23:0] put(logic [23:0] a, logic [1:0] n, logic [7:0] v);
    logic [23:0] r;
    r = a;
    case (n)
      2'd0:    r[7:0]   = v;
      2'd1:    r[15:8]  = v;
      default: r[23:16] = v;
    endcase
    return r;
  endfunction

  logic [23:0] bytes;
  logic [1:0]  n;
  logic [5:0]  m;
  logic [5:0]  m_nxt;
  logic [5:0]  code;
  logic [7:0]  base;
  logic [7:0]  lc;
  logic [7:0]  pc;
  logic        vow;
  logic        done;
  logic        is_upper;
  logic        is_lower;
  logic        is_lead;

  always_comb begin
    bytes       = '0;
    n           = '0;
    m           = mode_i;
    m_nxt       = mode_i;
    trail_nxt_o = trail_i;
    done        = 1'b0;
    pc          = char_byte_i;

    is_upper = char_byte_i inside {[ASC_UC_A:ASC_UC_Z]};
    is_lower = char_byte_i inside {[ASC_LC_A:ASC_LC_Z]};
    is_lead  = char_byte_i inside {[SJ_LEAD1_LO:SJ_LEAD1_HI], [SJ_LEAD2_LO:SJ_LEAD2_HI]};
    lc       = is_upper ? (char_byte_i + ASC_CASE) : char_byte_i;
    code     = letter_code(5'(lc - ASC_LC_A));
    vow      = lc inside {ASC_LC_A, ASC_I, ASC_U, ASC_E, ASC_O};
    base     = base_of_mode(mode_i);

    if (end_of_text_i) begin
      if (mode_i == PM_N) begin
        bytes = put(bytes, n, K_NN); n = n + 2'd1;
      end
      m_nxt       = PM_NONE;
      trail_nxt_o = 1'b0;
    end else if (trail_i) begin
      bytes = put(bytes, n, char_byte_i); n = n + 2'd1;
      trail_nxt_o = 1'b0;
    end else if (is_lead) begin
      bytes = put(bytes, n, char_byte_i); n = n + 2'd1;
      trail_nxt_o = 1'b1;
    end else if (is_upper || is_lower) begin
      // glide onto a consonant, or clear it when it takes no glide
      if (m != PM_NONE) begin
        if (m < Y_ROWS && lc == ASC_Y) begin
          code = y_glide(m);
          if (code != PM_NONE) begin
            m_nxt = code;
            done  = 1'b1;
          end
        end else if (m < W_ROWS && lc == ASC_W) begin
          code = w_glide(m);
          if (code != PM_NONE) begin
            m_nxt = code;
            done  = 1'b1;
          end
        end
      end
      if (!done) begin
        if (m == PM_T && lc == ASC_C) m = PM_C;
        if (!vow && code == m && m != PM_N && m != PM_M && m != PM_NONE) begin
          // doubled consonant
          bytes = put(bytes, n, K_SMALL_TU); n = n + 2'd1;
          m_nxt = m;
        end else if (m == PM_M && (code == PM_M || code == PM_B || code == PM_P)) begin
          bytes = put(bytes, n, K_NN); n = n + 2'd1;
          m_nxt = code;
        end else begin
          case (m)
            PM_NONE, PM_L, PM_S, PM_T: begin
              if (vow) begin
                bytes = put(bytes, n, 8'(base + {2'b00, code})); n = n + 2'd1;
              end else if (m == PM_L && lc == ASC_T) m = PM_LT;
              else if (m == PM_S && lc == ASC_H) m = PM_SH;
              else if (m == PM_T && lc == ASC_S) m = PM_TS;
              else m = code;
            end
            PM_N: begin
              if (vow) begin
                bytes = put(bytes, n, 8'(base + {2'b00, code})); n = n + 2'd1;
              end else begin
                bytes = put(bytes, n, K_NN); n = n + 2'd1;
                m = (lc == ASC_N) ? PM_NONE : code;
              end
            end
            PM_B, PM_G, PM_K, PM_M, PM_P, PM_R, PM_Z, PM_D: begin
              if (vow) begin
                bytes = put(bytes, n, 8'(base + {2'b00, code})); n = n + 2'd1;
                if (is_voiced(m)) begin
                  bytes = put(bytes, n, K_VOICED); n = n + 2'd1;
                end else if (m == PM_P) begin
                  bytes = put(bytes, n, K_SEMI); n = n + 2'd1;
                end
              end else if (m == PM_D && lc == ASC_H) m = PM_DH;
              else m = code;
            end
            PM_H: begin
              if (vow) begin
                bytes = put(bytes, n, 8'(base + {2'b00, code})); n = n + 2'd1;
              end else begin
                bytes = put(bytes, n, K_U); n = n + 2'd1;
                m = code;
              end
            end
            PM_C, PM_LT: begin
              if (m == PM_C && lc == ASC_H) m = PM_CH;
              else if (m == PM_LT && lc == ASC_U) begin
                bytes = put(bytes, n, K_SMALL_TU); n = n + 2'd1;
              end else m = code;
            end
            PM_F, PM_V, PM_TS: begin
              if (vow) begin
                bytes = put(bytes, n, 8'(base + 8'd2)); n = n + 2'd1;
                if (is_voiced(m)) begin
                  bytes = put(bytes, n, K_VOICED); n = n + 2'd1;
                end
                if (lc != ASC_U) begin
                  bytes = put(bytes, n, 8'(K_SMALL_A + {2'b00, code})); n = n + 2'd1;
                end
              end else m = code;
            end
            PM_W: begin
              if (lc == ASC_LC_A) begin
                bytes = put(bytes, n, K_WA); n = n + 2'd1;
              end else if (lc == ASC_I || lc == ASC_E) begin
                bytes = put(bytes, n, K_U); n = n + 2'd1;
                bytes = put(bytes, n, 8'(K_SMALL_A + {2'b00, code})); n = n + 2'd1;
              end else if (lc == ASC_U) begin
                bytes = put(bytes, n, K_U); n = n + 2'd1;
              end else if (lc == ASC_O) begin
                bytes = put(bytes, n, K_WO); n = n + 2'd1;
              end else m = code;
            end
            PM_Y: begin
              if (lc == ASC_LC_A) begin
                bytes = put(bytes, n, K_YA); n = n + 2'd1;
              end else if (lc == ASC_I) begin
                bytes = put(bytes, n, K_I); n = n + 2'd1;
              end else if (lc == ASC_U) begin
                bytes = put(bytes, n, K_YU); n = n + 2'd1;
              end else if (lc == ASC_E) begin
                bytes = put(bytes, n, K_I); n = n + 2'd1;
                bytes = put(bytes, n, K_SMALL_E); n = n + 2'd1;
              end else if (lc == ASC_O) begin
                bytes = put(bytes, n, K_YO); n = n + 2'd1;
              end else m = code;
            end
            PM_KY, PM_SY, PM_TY, PM_NY, PM_HY, PM_MY,
            PM_RY, PM_GY, PM_ZY, PM_DY, PM_BY, PM_PY: begin
              if (vow) begin
                bytes = put(bytes, n, 8'(base + 8'd1)); n = n + 2'd1;
                if (m == PM_PY) begin
                  bytes = put(bytes, n, K_SEMI); n = n + 2'd1;
                end else if (is_voiced(m)) begin
                  bytes = put(bytes, n, K_VOICED); n = n + 2'd1;
                end
                bytes = put(bytes, n, small_y(code)); n = n + 2'd1;
              end else m = code;
            end
            PM_J, PM_SH, PM_CH: begin
              if (vow) begin
                bytes = put(bytes, n, 8'(base + 8'd1)); n = n + 2'd1;
                if (is_voiced(m)) begin
                  bytes = put(bytes, n, K_VOICED); n = n + 2'd1;
                end
                if (lc != ASC_I) begin
                  bytes = put(bytes, n, small_y(code)); n = n + 2'd1;
                end
              end else m = code;
            end
            PM_FY: begin
              if (vow) begin
                bytes = put(bytes, n, 8'(base + 8'd2)); n = n + 2'd1;
                bytes = put(bytes, n, small_y(code)); n = n + 2'd1;
              end else m = code;
            end
            PM_LY: begin
              if (vow) begin
                bytes = put(bytes, n, small_y(code)); n = n + 2'd1;
              end else m = code;
            end
            PM_DH: begin
              if (vow) begin
                bytes = put(bytes, n, 8'(base + 8'd3)); n = n + 2'd1;
                bytes = put(bytes, n, K_VOICED); n = n + 2'd1;
                bytes = put(bytes, n, small_y(code)); n = n + 2'd1;
              end else m = code;
            end
            PM_GW, PM_HW, PM_KW, PM_NW: begin
              if (vow) begin
                bytes = put(bytes, n, 8'(base + 8'd2)); n = n + 2'd1;
                if (is_voiced(m)) begin
                  bytes = put(bytes, n, K_VOICED); n = n + 2'd1;
                end
                bytes = put(bytes, n, 8'(K_SMALL_A + {2'b00, code})); n = n + 2'd1;
              end else m = code;
            end
            default: begin
              // codes outside the mode set hold and emit nothing
            end
          endcase
          if (vow) m = PM_NONE;
          m_nxt = m;
        end
      end
    end else begin
      // punctuation remap, then pass through
      case (char_byte_i)
        ASC_DOT:   pc = K_PERIOD;
        ASC_LBR:   pc = K_LBRACKET;
        ASC_RBR:   pc = K_RBRACKET;
        ASC_COMMA: pc = K_COMMA;
        ASC_SLASH: pc = K_MIDDOT;
        default:   pc = char_byte_i;
      endcase
      if (mode_i == PM_N) begin
        bytes = put(bytes, n, K_NN); n = n + 2'd1;
        if (pc != ASC_APOS && pc != ASC_SPACE) begin
          bytes = put(bytes, n, pc); n = n + 2'd1;
        end
      end else begin
        bytes = put(bytes, n, pc); n = n + 2'd1;
      end
      m_nxt = PM_NONE;
    end

    res_o.bytes = bytes;
    res_o.count = n;
    mode_nxt_o  = mode_t'(m_nxt);
  end

endmodule

`default_nettype wire

// File: design/rtk_out_buf.sv
// result register that holds up to three bytes and hands them out one per transaction
`timescale 1ns / 1ps
`default_nettype none

module rtk_out_buf
  import rtk_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       load_i,
  input  wire res_t       res_i,
  output logic            free_o,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,
  output logic            out_tlast
);

  logic [1:0]  rem_r;
  logic [23:0] bytes_r;
  logic        hs;

  assign hs         = out_tvalid && out_tready;
  assign out_tvalid = rem_r != 2'd0;
  assign out_tdata  = bytes_r[7:0];
  assign out_tlast  = rem_r == 2'd1;
  assign free_o     = (rem_r == 2'd0) || (hs && rem_r == 2'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 2'd0;
    end else if (load_i) begin
      rem_r <= res_i.count;
    end else if (hs) begin
      rem_r <= rem_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      bytes_r <= res_i.bytes;
    end else if (hs) begin
      bytes_r <= {8'h00, bytes_r[23:8]};
    end
  end

endmodule

`default_nettype wire

// File: design/rtk_checker.sv
// port-level checker for the converter and its bind to the top level
`timescale 1ns / 1ps
`default_nettype none

module rtk_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tready,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // a run continues without a gap after a non-final result
  a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("gap inside a run of results");

  // no run is longer than three results
  a_run_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast ##1 out_tvalid && out_tready && !out_tlast
    |=> out_tlast)
    else $error("run longer than three results");

  // with nothing waiting on the output side the input is never held off
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input held off with an empty result register");

endmodule

bind romaji_to_kana_converter rtk_checker u_rtk_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire

// File: verif/romaji_to_kana_converter_tb.sv
// self-checking testbench for the romaji to kana converter with a predicting scoreboard
`timescale 1ns / 1ps

module romaji_to_kana_converter_tb;
  import rtk_pkg::*;

  // expected kana stream, built from every accepted input transaction
  class kana_scoreboard;
    typedef struct {
      logic [7:0] kana;
      logic       last;
    } kana_res_t;

    kana_res_t   expected_kana[$];
    logic [7:0]  burst[$];
    logic [5:0]  cons = PM_NONE;
    bit          sjis_trail = 1'b0;
    int unsigned failures = 0;

    function void put(logic [7:0] b);
      if (burst.size() < 3) burst.push_back(b);
    endfunction

    function logic [7:0] row_kana(logic [5:0] m);
      case (m)
        PM_NONE, PM_V:                   return K_A;
        PM_K, PM_G, PM_KY, PM_GY:        return K_KA;
        PM_KW, PM_GW:                    return K_KA;
        PM_S, PM_C, PM_Z, PM_J:          return K_SA;
        PM_SY, PM_SH, PM_ZY:             return K_SA;
        PM_T, PM_D, PM_TY, PM_CH:        return K_TA;
        PM_TS, PM_DY, PM_DH:             return K_TA;
        PM_N, PM_NY, PM_NW:              return K_NA;
        PM_H, PM_F, PM_B, PM_P, PM_HY:   return K_HA;
        PM_FY, PM_BY, PM_PY, PM_HW:      return K_HA;
        PM_M, PM_MY:                     return K_MA;
        PM_Y:                            return K_YA;
        PM_R, PM_RY:                     return K_RA;
        PM_W:                            return K_WA;
        PM_L:                            return K_SMALL_A;
        PM_LY:                           return K_SMALL_YA;
        PM_LT:                           return K_SMALL_TU;
        default:                         return 8'h00;
      endcase
    endfunction

    // vowels give their column (a i u e o), consonants the mode they open
    function logic [5:0] letter_col(logic [7:0] c);
      case (c)
        "a": return 6'd0;
        "i": return 6'd1;
        "u": return 6'd2;
        "e": return 6'd3;
        "o": return 6'd4;
        "b": return PM_B;
        "c": return PM_C;
        "d": return PM_D;
        "f": return PM_F;
        "g": return PM_G;
        "h": return PM_H;
        "j": return PM_J;
        "k": return PM_K;
        "l", "x": return PM_L;
        "m": return PM_M;
        "n": return PM_N;
        "p": return PM_P;
        "r": return PM_R;
        "s": return PM_S;
        "t": return PM_T;
        "v": return PM_V;
        "w": return PM_W;
        "y": return PM_Y;
        "z": return PM_Z;
        default: return PM_NONE;
      endcase
    endfunction

    function logic [5:0] y_pair(logic [5:0] m);
      case (m)
        PM_K:       return PM_KY;
        PM_S:       return PM_SY;
        PM_T, PM_C: return PM_TY;
        PM_N:       return PM_NY;
        PM_H:       return PM_HY;
        PM_F:       return PM_FY;
        PM_M:       return PM_MY;
        PM_R:       return PM_RY;
        PM_L:       return PM_LY;
        PM_G:       return PM_GY;
        PM_Z, PM_J: return PM_ZY;
        PM_D:       return PM_DY;
        PM_B:       return PM_BY;
        PM_P:       return PM_PY;
        default:    return PM_NONE;
      endcase
    endfunction

    function logic [5:0] w_pair(logic [5:0] m);
      case (m)
        PM_K:    return PM_KW;
        PM_N:    return PM_NW;
        PM_H:    return PM_HW;
        PM_G:    return PM_GW;
        default: return PM_NONE;
      endcase
    endfunction

    function logic [7:0] small_y_kana(logic [5:0] v);
      case (v)
        6'd0:    return K_SMALL_YA;
        6'd1:    return 8'hA8;
        6'd2:    return 8'hAD;
        6'd3:    return K_SMALL_E;
        6'd4:    return 8'hAE;
        default: return 8'h00;
      endcase
    endfunction

    function bit voiced_mode(logic [5:0] m);
      return (m >= PM_G && m <= PM_B) || m == PM_V ||
             (m >= PM_GY && m <= PM_BY) || m == PM_GW;
    endfunction

    function void take_letter(logic [7:0] c);
      logic [5:0] m;
      logic [5:0] code;
      logic [7:0] row;
      bit         vow;
      m    = cons;
      code = letter_col(c);
      vow  = (c == "a" || c == "i" || c == "u" || c == "e" || c == "o");
      row  = (m <= PM_GW) ? row_kana(m) : 8'h00;
      // glides only from a plain consonant; a failed glide leaves code at none
      if (m != PM_NONE) begin
        if (m < Y_ROWS && c == "y") begin
          code = y_pair(m);
          if (code != PM_NONE) begin
            cons = code;
            return;
          end
        end else if (m < W_ROWS && c == "w") begin
          code = w_pair(m);
          if (code != PM_NONE) begin
            cons = code;
            return;
          end
        end
      end
      if (m == PM_T && c == "c") m = PM_C;
      if (!vow && code == m && m != PM_N && m != PM_M && m != PM_NONE) begin
        put(K_SMALL_TU);
        cons = m;
        return;
      end
      if (m == PM_M && (code == PM_M || code == PM_B || code == PM_P)) begin
        put(K_NN);
        cons = code;
        return;
      end
      case (m)
        PM_NONE, PM_L, PM_S, PM_T: begin
          if (vow) put(row + code);
          else if (m == PM_L && c == "t") m = PM_LT;
          else if (m == PM_S && c == "h") m = PM_SH;
          else if (m == PM_T && c == "s") m = PM_TS;
          else m = code;
        end
        PM_N: begin
          if (vow) put(row + code);
          else begin
            put(K_NN);
            if (c == "n") m = PM_NONE;
            else m = code;
          end
        end
        PM_B, PM_G, PM_K, PM_M, PM_P, PM_R, PM_Z, PM_D: begin
          if (vow) begin
            put(row + code);
            if (voiced_mode(m)) put(K_VOICED);
            else if (m == PM_P) put(K_SEMI);
          end else if (m == PM_D && c == "h") m = PM_DH;
          else m = code;
        end
        PM_H: begin
          if (vow) put(row + code);
          else begin
            put(K_U);
            m = code;
          end
        end
        PM_C, PM_LT: begin
          if (m == PM_C && c == "h") m = PM_CH;
          else if (m == PM_LT && c == "u") put(K_SMALL_TU);
          else m = code;
        end
        PM_F, PM_V, PM_TS: begin
          if (vow) begin
            put(row + 8'd2);
            if (voiced_mode(m)) put(K_VOICED);
            if (c != "u") put(K_SMALL_A + code);
          end else m = code;
        end
        PM_W: begin
          if (c == "a") put(K_WA);
          else if (c == "i" || c == "e") begin
            put(K_U);
            put(K_SMALL_A + code);
          end else if (c == "u") put(K_U);
          else if (c == "o") put(K_WO);
          else m = code;
        end
        PM_Y: begin
          if (c == "a") put(K_YA);
          else if (c == "i") put(K_I);
          else if (c == "u") put(K_YU);
          else if (c == "e") begin
            put(K_I);
            put(K_SMALL_E);
          end else if (c == "o") put(K_YO);
          else m = code;
        end
        PM_KY, PM_SY, PM_TY, PM_NY, PM_HY, PM_MY,
        PM_RY, PM_GY, PM_ZY, PM_DY, PM_BY, PM_PY: begin
          if (vow) begin
            put(row + 8'd1);
            if (m == PM_PY) put(K_SEMI);
            else if (voiced_mode(m)) put(K_VOICED);
            put(small_y_kana(code));
          end else m = code;
        end
        PM_J, PM_SH, PM_CH: begin
          if (vow) begin
            put(row + 8'd1);
            if (voiced_mode(m)) put(K_VOICED);
            if (c != "i") put(small_y_kana(code));
          end else m = code;
        end
        PM_FY: begin
          if (vow) begin
            put(row + 8'd2);
            put(small_y_kana(code));
          end else m = code;
        end
        PM_LY: begin
          if (vow) put(small_y_kana(code));
          else m = code;
        end
        PM_DH: begin
          if (vow) begin
            put(row + 8'd3);
            put(K_VOICED);
            put(small_y_kana(code));
          end else m = code;
        end
        PM_GW, PM_HW, PM_KW, PM_NW: begin
          if (vow) begin
            put(row + 8'd2);
            if (voiced_mode(m)) put(K_VOICED);
            put(K_SMALL_A + code);
          end else m = code;
        end
        default: ;
      endcase
      if (vow) m = PM_NONE;
      cons = m;
    endfunction

    function void take_other(logic [7:0] c);
      logic [7:0] k;
      case (c)
        ASC_DOT:   k = K_PERIOD;
        ASC_LBR:   k = K_LBRACKET;
        ASC_RBR:   k = K_RBRACKET;
        ASC_COMMA: k = K_COMMA;
        ASC_SLASH: k = K_MIDDOT;
        default:   k = c;
      endcase
      if (cons == PM_N) begin
        put(K_NN);
        if (k != ASC_APOS && k != ASC_SPACE) put(k);
      end else begin
        put(k);
      end
      cons = PM_NONE;
    endfunction

    function void note_input(logic [7:0] c, logic eot);
      kana_res_t r;
      burst.delete();
      if (eot) begin
        if (cons == PM_N) put(K_NN);
        cons       = PM_NONE;
        sjis_trail = 1'b0;
      end else if (sjis_trail) begin
        put(c);
        sjis_trail = 1'b0;
      end else if ((c >= SJ_LEAD1_LO && c <= SJ_LEAD1_HI) ||
                   (c >= SJ_LEAD2_LO && c <= SJ_LEAD2_HI)) begin
        put(c);
        sjis_trail = 1'b1;
      end else if (c >= ASC_UC_A && c <= ASC_UC_Z) begin
        take_letter(c | ASC_CASE);
      end else if (c >= ASC_LC_A && c <= ASC_LC_Z) begin
        take_letter(c);
      end else begin
        take_other(c);
      end
      foreach (burst[i]) begin
        r.kana = burst[i];
        r.last = (i == burst.size() - 1);
        expected_kana.push_back(r);
      end
    endfunction

    function void check_result(logic [7:0] kana, logic last);
      kana_res_t r;
      if (expected_kana.size() == 0) begin
        $error("kana_byte %02h arrived with no result expected", kana);
        failures++;
        return;
      end
      r = expected_kana.pop_front();
      if (kana !== r.kana) begin
        $error("kana_byte mismatch: expected %02h, actual %02h", r.kana, kana);
        failures++;
      end
      if (last !== r.last) begin
        $error("last_of_run mismatch: expected %0b, actual %0b", r.last, last);
        failures++;
      end
    endfunction
  endclass

  localparam int ITEM_TARGET = 210;   // directed plus random input transactions
  localparam int STALL_LIMIT = 1000;  // cycles with no transaction on either side
  localparam int HOLD_CYCLES = 70;    // long receiver hold-off, far beyond the buffering

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;       // [7:0] char_byte
  logic       in_tlast = 1'b0;        // end_of_text
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;              // [7:0] kana_byte
  logic       out_tlast;              // last_of_run

  kana_scoreboard sb = new();

  int unsigned sent_count = 0;
  int unsigned stall_cycles = 0;
  int unsigned hold_left = 0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  bit          tx_gaps = 1'b1;
  bit          rx_gaps = 1'b1;

  // opening pass: {end_of_text, char_byte}
  logic [8:0] opening_items[] = '{
    {1'b0, 8'h00},  // zero byte passes through
    {1'b0, 8'hFF},  // top byte, not a lead byte
    {1'b0, 8'h81},  // shift-jis lead
    {1'b0, 8'h00},  // trail taken as is
    {1'b0, "n"},
    {1'b0, "'"},    // apostrophe after n: only the n comes out
    {1'b0, "N"},
    {1'b0, "."},    // n then remapped period
    {1'b0, "k"},
    {1'b0, "k"},    // doubled consonant -> small tsu
    {1'b0, "a"},
    {1'b0, "h"},
    {1'b0, "k"},    // h before a consonant
    {1'b0, "y"},
    {1'b0, "o"},    // palatal glide
    {1'b0, "w"},
    {1'b0, "y"},    // y with no glide drops the w
    {1'b0, "d"},
    {1'b0, "h"},
    {1'b0, "i"},    // three results from one byte
    {1'b0, "m"},
    {1'b0, "p"},    // m before p -> n
    {1'b0, "a"},    // semi-voiced mark
    {1'b0, 8'hFC},  // lead byte, then end of text cuts the pair
    {1'b1, 8'hFF},
    {1'b0, "n"},
    {1'b1, 8'h00}   // end of text flushes the n
  };

  string syllables[] = '{
    "a", "i", "u", "e", "o", "ka", "ki", "shi", "chi", "tsu", "fu", "fa", "vi", "ve",
    "kya", "gyu", "jo", "ja", "sha", "cho", "nya", "hyo", "fyu", "myo", "ryu", "zyo",
    "dyu", "dhi", "bye", "pya", "pyo", "ltu", "lya", "xyo", "xi", "wa", "wi", "we",
    "wo", "ya", "yi", "ye", "yo", "kwa", "gwi", "nwo", "hwe", "kka", "tte", "ssa",
    "ppu", "tcha", "nn", "n'", "n ", "mba", "mpi", "mma", "ne", "zu", "di", "ga",
    "pe", "bo", "dwu", "hta", "qa", "cyo", "tsa", "lte", "jji", "ru", "n."
  };
  string marks = ".[],/' -!0";

  romaji_to_kana_converter DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #4 clk = ~clk;

  // both sides sampled at the edge, input first so its results are queued before any check
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_input(in_tdata, in_tlast);
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
    end
  end

  // receiver: random back-pressure, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done  <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !(rx_gaps && $urandom_range(99) < 18);
    end
  end

  // watchdog on cycles where neither side moves a transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("romaji_to_kana_converter_tb: FAIL");
      $finish;
    end
  end

  // offer one byte and hold it until the transaction completes
  task automatic send_item(input logic [7:0] b, input logic eot);
    if (tx_gaps && $urandom_range(99) < 18) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eot;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_count++;
  endtask

  initial begin : stimulus
    string      syl;
    logic [7:0] b;
    int unsigned kind;
    bit         quiet;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (opening_items[k]) send_item(opening_items[k][7:0], opening_items[k][8]);

    while (sent_count < ITEM_TARGET) begin
      // long receiver stall partway through, sender keeps pushing
      if (sent_count >= 90 && !hold_req) hold_req <= 1'b1;
      // a stretch with no idling on either side
      quiet   = (sent_count >= 130 && sent_count < 180);
      tx_gaps = !quiet;
      rx_gaps <= !quiet;
      kind = $urandom_range(99);
      if (kind < 60) begin
        // well-formed syllable, sometimes in capitals
        syl = syllables[$urandom_range(syllables.size() - 1)];
        for (int i = 0; i < syl.len(); i++) begin
          b = syl[i];
          if (b >= ASC_LC_A && b <= ASC_LC_Z && $urandom_range(9) == 0) b = b - ASC_CASE;
          send_item(b, 1'b0);
        end
      end else if (kind < 70) begin
        send_item(marks[$urandom_range(marks.len() - 1)], 1'b0);
      end else if (kind < 78) begin
        // shift-jis pair, now and then broken by end of text
        if ($urandom_range(1)) b = 8'($urandom_range(SJ_LEAD1_HI, SJ_LEAD1_LO));
        else b = 8'($urandom_range(SJ_LEAD2_HI, SJ_LEAD2_LO));
        send_item(b, 1'b0);
        if ($urandom_range(9) == 0) send_item(8'($urandom_range(255)), 1'b1);
        else send_item(8'($urandom_range(255)), 1'b0);
      end else if (kind < 84) begin
        send_item(8'($urandom_range(255)), 1'b1);
      end else begin
        send_item(8'($urandom_range(255)), 1'b0);
      end
    end
    in_tvalid <= 1'b0;

    // let the monitor log the last transaction, drain, then watch for any stray result
    @(posedge clk);
    while (sb.expected_kana.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (sb.failures == 0) $display("romaji_to_kana_converter_tb: PASS");
    else $display("romaji_to_kana_converter_tb: FAIL");
    $finish;
  end

endmodule
